// ----- hdl/lqr_pkg.sv -----
package lqr_pkg;

  localparam int ID_W  = 6;
  localparam int ID_N  = 1 << ID_W;
  localparam int CNT_W = ID_W + 1;

  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_REM = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_DUP      = 2'd3;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] entry_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] out_entry;
    logic            out_valid;
    logic [1:0]      status;
    logic            now_empty;
  } res_t;

  typedef struct packed {
    logic            shift;
    logic            wr_en;
    logic [ID_W-1:0] wr_pos;
    logic [ID_W-1:0] wr_id;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/lqr_cell.sv -----
module lqr_cell #(
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  lqr_pkg::cell_ctl_t      ctl,
  input  logic [lqr_pkg::ID_W-1:0] right_id,
  output logic [lqr_pkg::ID_W-1:0] id_q
);
  import lqr_pkg::*;

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;

  always_comb begin
    id_nxt = id_r;
    if (ctl.shift) begin
      id_nxt = right_id;
    end
    if (ctl.wr_en && (ctl.wr_pos == ID_W'(INDEX))) begin
      id_nxt = ctl.wr_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q = id_r;

endmodule

// ----- hdl/lqr_ctrl.sv -----
module lqr_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lqr_pkg::req_t            in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lqr_pkg::res_t            out_data,
  input  logic [lqr_pkg::ID_W-1:0] head_id,
  output lqr_pkg::cell_ctl_t       ctl
);
  import lqr_pkg::*;

  localparam int NCELL = (DEPTH < ID_N) ? DEPTH : ID_N;
  localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  logic [ID_W-1:0]    key_r, key_nxt;
  logic [NCELL-1:0]   mbr_r, mbr_nxt;
  logic               out_vld_r, out_vld_nxt;
  res_t               out_res_r, out_res_nxt;

  logic               in_acc;
  logic               out_free;
  logic               id_ok;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   head_idx;
  logic               rem_ok;
  logic [CNT_W-1:0]   cnt_dec;

  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign id_ok    = {1'b0, in_data.entry_id} < CNT_W'(NCELL);
  assign in_idx   = in_data.entry_id[IDX_W-1:0];
  assign head_idx = head_id[IDX_W-1:0];
  assign rem_ok   = id_ok && mbr_r[in_idx];
  assign cnt_dec  = cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_REM) && rem_ok) begin
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    cnt_nxt     = cnt_r;
    steps_nxt   = steps_r;
    key_nxt     = key_r;
    mbr_nxt     = mbr_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_res_nxt = out_res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_vld_nxt           = 1'b1;
          out_res_nxt.out_entry = '0;
          out_res_nxt.out_valid = 1'b0;
          out_res_nxt.status    = STS_OK;
          out_res_nxt.now_empty = (cnt_r == '0);
          unique case (in_data.req_type)
            REQ_ENQ: begin
              if (!id_ok || mbr_r[in_idx]) begin
                out_res_nxt.status = STS_DUP;
              end else begin
                ctl.wr_en             = 1'b1;
                ctl.wr_pos            = cnt_r[ID_W-1:0];
                ctl.wr_id             = in_data.entry_id;
                cnt_nxt               = cnt_r + CNT_W'(1);
                mbr_nxt[in_idx]       = 1'b1;
                out_res_nxt.now_empty = 1'b0;
              end
            end
            REQ_DEQ: begin
              if (cnt_r == '0) begin
                out_res_nxt.status = STS_EMPTY;
              end else begin
                ctl.shift             = 1'b1;
                cnt_nxt               = cnt_dec;
                mbr_nxt[head_idx]     = 1'b0;
                out_res_nxt.out_entry = head_id;
                out_res_nxt.out_valid = 1'b1;
                out_res_nxt.now_empty = (cnt_r == CNT_W'(1));
              end
            end
            REQ_REM: begin
              if (!rem_ok) begin
                out_res_nxt.status = STS_NOTFOUND;
              end else begin
                out_vld_nxt     = 1'b0;
                key_nxt         = in_data.entry_id;
                steps_nxt       = cnt_r;
                mbr_nxt[in_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROT: begin
        ctl.shift = 1'b1;
        steps_nxt = steps_r - CNT_W'(1);
        if (head_id == key_r) begin
          cnt_nxt = cnt_dec;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_pos = cnt_dec[ID_W-1:0];
          ctl.wr_id  = head_id;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_nxt           = 1'b1;
          out_res_nxt.out_entry = '0;
          out_res_nxt.out_valid = 1'b0;
          out_res_nxt.status    = STS_OK;
          out_res_nxt.now_empty = (cnt_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      steps_r   <= '0;
      mbr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      steps_r   <= steps_nxt;
      mbr_r     <= mbr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NCELL))
    else $error("entry count beyond cell count");

  a_mbr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROT) |-> ($countones(mbr_r) == int'(cnt_r)))
    else $error("membership bits disagree with entry count");

  a_rot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) |-> ((cnt_r != '0) && (steps_r != '0) && !out_vld_nxt))
    else $error("rotation on empty queue or with a result pending");

endmodule

// ----- hdl/linked_queue_with_removal_unit.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | in_data   (req_type, entry_id)
// out      | out_valid / out_stall| out_data  (out_entry, out_valid, status, now_empty)
//
// Enqueue, dequeue, a failed remove and an undefined request register their result
// in the cycle after the transfer in. A remove that finds its entry rotates the cell
// row once per queued entry, one cell per cycle, then registers its result from ST_FIN.
// Reset clears the state, the count, the membership bits and the output valid bit.
// in_stall is high while a rotation runs or finishes, or while a result waits under out_stall.
module linked_queue_with_removal_unit #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lqr_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lqr_pkg::res_t out_data
);
  import lqr_pkg::*;

  localparam int NCELL = (DEPTH < ID_N) ? DEPTH : ID_N;

  cell_ctl_t       ctl;
  logic [ID_W-1:0] cell_id [NCELL];

  lqr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .head_id  (cell_id[0]),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [ID_W-1:0] right_id;
    if (i == NCELL - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_mid
      assign right_id = cell_id[i+1];
    end
    lqr_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .right_id(right_id),
      .id_q    (cell_id[i])
    );
  end

endmodule
